// ----- hdl/threshold_box_dilation_mask_top_macros.svh -----
// Assertion macros shared by the checker of the threshold box dilation mask block.
// The macros expect signals named clk and arst_n in the scope where they are used.
`ifndef THRESHOLD_BOX_DILATION_MASK_TOP_MACROS_SVH
`define THRESHOLD_BOX_DILATION_MASK_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBDM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TBDM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/tbdm_pkg.sv -----
// Package of the threshold box dilation mask block: widths, reset values and register indexes.
// Used by the top level and the checker; it depends on nothing else.
`timescale 1ns / 1ps
package tbdm_pkg;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int DEF_MAX_RADIUS = 16;

	localparam int PIXEL_W    = 32;
	localparam int THRESH_W   = 32;
	localparam int GEOM_W     = 13;
	localparam int RADIUS_W   = 5;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	localparam logic signed [THRESH_W-1:0] RST_THRESHOLD    = '0;
	localparam logic [GEOM_W-1:0]          RST_FRAME_WIDTH  = 13'd4096;
	localparam logic [GEOM_W-1:0]          RST_FRAME_HEIGHT = 13'd4096;
	localparam logic [RADIUS_W-1:0]        RST_BOX_RADIUS   = 5'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD    = 2'd0,
		REG_FRAME_WIDTH  = 2'd1,
		REG_FRAME_HEIGHT = 2'd2,
		REG_BOX_RADIUS   = 2'd3
	} cfg_reg_t;

endpackage

// ----- hdl/tbdm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port (read-first).
// Stand-alone; no package needed.
`timescale 1ns / 1ps
module tbdm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/threshold_box_dilation_mask_top.sv -----
// Threshold and square dilation mask: one request in, one mask request out, per cycle.
// Uses tbdm_pkg and tbdm_ram. Each rate here holds only while no stall is raised.
// Throughput: one request per cycle, set by one read-modify-write of the column-count RAM.
// A configuration write stalls the input while frame sizes are recomputed.
// Reset (async, active low) empties the pipeline and restores register defaults; the RAM
// needs no clearing pass, since the first image row treats every column as unmarked.
`timescale 1ns / 1ps
module threshold_box_dilation_mask_top #(
	parameter int MAX_WIDTH  = tbdm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = tbdm_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = tbdm_pkg::DEF_MAX_RADIUS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [tbdm_pkg::PIXEL_W-1:0]   pixel_value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  mask_bit,
	output logic                                  mask_valid,
	output logic                                  frame_last,
	output logic                                  any_significant,
	input  logic                                  cfg_we,
	input  logic [tbdm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tbdm_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// Column index, clamped geometry, row, item index and counter widths.
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int RDW  = $clog2(MAX_RADIUS + 1);
	localparam int RW   = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 2);
	localparam int TW   = $clog2(MAX_WIDTH * (MAX_HEIGHT + MAX_RADIUS + 1) + 1);
	localparam int NW   = $clog2(2 * MAX_RADIUS + 2);
	localparam int PW   = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1;
	localparam int CMPW = ((CW > RDW) ? CW : RDW) + 3;

	localparam logic [NW-1:0] COUNT_SAT     = NW'(2 * MAX_RADIUS + 1);
	localparam logic [1:0]    SETTLE_CYCLES = 2'd2;

	// ------------------------------------------------------------------
	// Configuration registers. Any write restarts a short settle window in
	// which the derived frame sizes are recomputed and no request is taken.
	// A write to the geometry also abandons the frame in progress.
	// ------------------------------------------------------------------
	logic signed [tbdm_pkg::THRESH_W-1:0] threshold_q;
	logic [tbdm_pkg::GEOM_W-1:0]          frame_width_q;
	logic [tbdm_pkg::GEOM_W-1:0]          frame_height_q;
	logic [tbdm_pkg::RADIUS_W-1:0]        box_radius_q;
	logic [1:0]                           settle_q;
	logic                                 geom_write;

	assign geom_write = cfg_we && (cfg_index != tbdm_pkg::REG_THRESHOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= tbdm_pkg::RST_THRESHOLD;
			frame_width_q  <= tbdm_pkg::RST_FRAME_WIDTH;
			frame_height_q <= tbdm_pkg::RST_FRAME_HEIGHT;
			box_radius_q   <= tbdm_pkg::RST_BOX_RADIUS;
			settle_q       <= SETTLE_CYCLES;
		end else begin
			if (cfg_we) begin
				settle_q <= SETTLE_CYCLES;
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end
			if (cfg_we) begin
				unique case (tbdm_pkg::cfg_reg_t'(cfg_index))
					tbdm_pkg::REG_THRESHOLD: begin
						threshold_q <= cfg_data[tbdm_pkg::THRESH_W-1:0];
					end
					tbdm_pkg::REG_FRAME_WIDTH: begin
						frame_width_q <= cfg_data[tbdm_pkg::GEOM_W-1:0];
					end
					tbdm_pkg::REG_FRAME_HEIGHT: begin
						frame_height_q <= cfg_data[tbdm_pkg::GEOM_W-1:0];
					end
					tbdm_pkg::REG_BOX_RADIUS: begin
						box_radius_q <= cfg_data[tbdm_pkg::RADIUS_W-1:0];
					end
				endcase
			end
		end
	end

	// Out-of-range geometry is clamped into what the storage can hold.
	logic [WW-1:0]  w_eff;
	logic [HW-1:0]  h_eff;
	logic [RDW-1:0] r_eff;
	logic [CW-1:0]  w_last;
	logic [RDW:0]   r_twice;

	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(frame_height_q);
		end
		if (32'(box_radius_q) > 32'(MAX_RADIUS)) begin
			r_eff = RDW'(MAX_RADIUS);
		end else begin
			r_eff = RDW'(box_radius_q);
		end
	end

	assign w_last  = CW'(w_eff - WW'(1));
	assign r_twice = {r_eff, 1'b0};

	// Frame sizes in items, worked out in registers: products first,
	// then the drain length and the index of the final item of a frame.
	logic [TW-1:0] prod_rw_q;
	logic [TW-1:0] prod_wh_q;
	logic [TW-1:0] drain_q;
	logic [TW-1:0] last_t_q;

	always_ff @(posedge clk) begin
		prod_rw_q <= TW'(r_eff) * TW'(w_eff);
		prod_wh_q <= TW'(w_eff) * TW'(h_eff);
		drain_q   <= prod_rw_q + TW'(r_eff);
		last_t_q  <= prod_wh_q + prod_rw_q + TW'(r_eff) - TW'(1);
	end

	// ------------------------------------------------------------------
	// Handshake. The stage-one register and the output register form a
	// two-deep path, so a new request is taken while a result waits.
	// ------------------------------------------------------------------
	logic s1_valid_q;
	logic out_valid_q;
	logic in_accept;
	logic s1_adv;

	assign s1_adv    = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall  = (settle_q != 2'd0) || (s1_valid_q && !s1_adv);
	assign in_accept = in_valid && !in_stall;

	// ------------------------------------------------------------------
	// Stage zero: raster position of the incoming request, and of the
	// delayed position whose mask bit it carries. The column-count RAM is
	// read here; its data arrives with the request in stage one.
	// ------------------------------------------------------------------
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [TW-1:0] t_q;
	logic [CW-1:0] ox_q;
	logic [RW-1:0] oy_q;

	logic          pix_sig;
	logic          item_valid;
	logic          item_last;
	logic          row_end;
	logic [RW-1:0] k_full;
	logic          k_zero;
	logic          k_in;
	logic [PW-1:0] k_idx;

	assign pix_sig    = (row_q < RW'(h_eff)) && (pixel_value >= threshold_q);
	assign item_valid = t_q >= drain_q;
	assign item_last  = t_q == last_t_q;
	assign row_end    = col_q == w_last;

	// Row distance between the input row and the delayed row, less the radius.
	// Zero means the delayed row's horizontal pass is still the current row.
	assign k_full = row_q - oy_q - RW'(r_eff);
	assign k_zero = k_full == '0;
	assign k_in   = !k_zero && (k_full <= RW'(MAX_RADIUS));
	assign k_idx  = PW'(k_full - RW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			t_q   <= '0;
			ox_q  <= '0;
			oy_q  <= '0;
		end else if (geom_write) begin
			col_q <= '0;
			row_q <= '0;
			t_q   <= '0;
			ox_q  <= '0;
			oy_q  <= '0;
		end else if (in_accept) begin
			if (item_last) begin
				col_q <= '0;
				row_q <= '0;
				t_q   <= '0;
				ox_q  <= '0;
				oy_q  <= '0;
			end else begin
				t_q <= t_q + TW'(1);
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
				if (item_valid) begin
					if (ox_q == w_last) begin
						ox_q <= '0;
						oy_q <= oy_q + RW'(1);
					end else begin
						ox_q <= ox_q + CW'(1);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage one: column counter update (vertical pass) and the horizontal
	// pass over the last covered column of each recent row.
	// ------------------------------------------------------------------
	logic [CW-1:0] col_s1;
	logic [CW-1:0] x_s1;
	logic          sig_s1;
	logic          valid_s1;
	logic          last_s1;
	logic          rowend_s1;
	logic          row0_s1;
	logic          kzero_s1;
	logic          kin_s1;
	logic [PW-1:0] kidx_s1;
	logic          fwd_s1;
	logic [NW-1:0] fwd_data_s1;

	logic [NW-1:0] ram_rdata;
	logic [NW-1:0] cnt_old;
	logic [NW-1:0] cnt_new;
	logic          covered;
	logic [CW:0]   cur_q;
	logic [CW:0]   cur_new;
	logic [CW:0]   prev_q [MAX_RADIUS];
	logic [CW:0]   prev_sel;
	logic          has_sig_q;
	logic          has_sig_new;
	logic          bit_here;
	logic          bit_prev;
	logic          bit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// With a one-column frame the same RAM entry is read while the request
	// ahead is writing it; the written value is forwarded instead.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			col_s1      <= col_q;
			x_s1        <= ox_q;
			sig_s1      <= pix_sig;
			valid_s1    <= item_valid;
			last_s1     <= item_last;
			rowend_s1   <= row_end;
			row0_s1     <= row_q == '0;
			kzero_s1    <= k_zero;
			kin_s1      <= k_in;
			kidx_s1     <= k_idx;
			fwd_s1      <= s1_adv && (col_s1 == col_q);
			fwd_data_s1 <= cnt_new;
		end
	end

	tbdm_ram #(
		.WIDTH (NW),
		.DEPTH (MAX_WIDTH)
	) u_count_ram (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata (cnt_new),
		.re    (in_accept),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	// The first row of a frame is the first visit to every column, so the RAM
	// contents left by an earlier frame are never looked at.
	always_comb begin
		if (row0_s1) begin
			cnt_old = COUNT_SAT;
		end else if (fwd_s1) begin
			cnt_old = fwd_data_s1;
		end else begin
			cnt_old = ram_rdata;
		end
		if (sig_s1) begin
			cnt_new = '0;
		end else if (cnt_old < COUNT_SAT) begin
			cnt_new = cnt_old + NW'(1);
		end else begin
			cnt_new = cnt_old;
		end
	end

	assign covered     = CMPW'(cnt_new) <= CMPW'(r_twice);
	assign cur_new     = covered ? ((CW + 1)'(col_s1) + (CW + 1)'(1)) : cur_q;
	assign prev_sel    = prev_q[kidx_s1];
	assign has_sig_new = has_sig_q || sig_s1;

	// Covered columns are kept as column plus one, zero meaning none. In the
	// current row the test looks back a full box width from the input column.
	assign bit_here = (cur_new != '0) &&
		(CMPW'(cur_new) + CMPW'(r_twice) > CMPW'(col_s1));
	assign bit_prev = (prev_sel != '0) &&
		(CMPW'(prev_sel) + CMPW'(r_eff) > CMPW'(x_s1));
	assign bit_s1   = valid_s1 && (kzero_s1 ? bit_here : (kin_s1 && bit_prev));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			has_sig_q <= 1'b0;
			for (int i = 0; i < MAX_RADIUS; i++) begin
				prev_q[i] <= '0;
			end
		end else if (geom_write || (s1_adv && last_s1)) begin
			cur_q     <= '0;
			has_sig_q <= 1'b0;
			for (int i = 0; i < MAX_RADIUS; i++) begin
				prev_q[i] <= '0;
			end
		end else if (s1_adv) begin
			has_sig_q <= has_sig_new;
			if (rowend_s1) begin
				cur_q <= '0;
				for (int i = MAX_RADIUS - 1; i > 0; i--) begin
					prev_q[i] <= prev_q[i-1];
				end
				prev_q[0] <= cur_new;
			end else begin
				cur_q <= cur_new;
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register: holds a result until the far side takes it.
	// ------------------------------------------------------------------
	logic mask_bit_q;
	logic mask_valid_q;
	logic frame_last_q;
	logic any_sig_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			mask_bit_q   <= bit_s1;
			mask_valid_q <= valid_s1;
			frame_last_q <= last_s1;
			any_sig_q    <= has_sig_new;
		end
	end

	assign out_valid       = out_valid_q;
	assign mask_bit        = mask_bit_q;
	assign mask_valid      = mask_valid_q;
	assign frame_last      = frame_last_q;
	assign any_significant = any_sig_q;

endmodule

// ----- hdl/tbdm_checker.sv -----
// Port-level checker for the threshold box dilation mask top level, bound to it below.
// Depends on tbdm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "threshold_box_dilation_mask_top_macros.svh"
module tbdm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           mask_bit,
	input logic                           mask_valid,
	input logic                           frame_last,
	input logic                           any_significant,
	input logic                           cfg_we,
	input logic [tbdm_pkg::CFG_IDX_W-1:0] cfg_index
);

	// Any configuration write, geometry or threshold, must be followed by the settle stall.
	logic geom_write;
	assign geom_write = cfg_we && (cfg_index != tbdm_pkg::REG_THRESHOLD);

	`TBDM_ASSERT_SAME(a_bit_needs_valid, out_valid && !mask_valid, !mask_bit, "mask bit without position")
	`TBDM_ASSERT_SAME(a_bit_needs_sig, out_valid && mask_bit, any_significant, "mask bit before any significant pixel")
	`TBDM_ASSERT_NEXT(a_cfg_settle, cfg_we || geom_write, in_stall, "request taken straight after a configuration write")
	`TBDM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(mask_bit) && $stable(mask_valid) && $stable(frame_last) && $stable(any_significant), "stalled result changed")

endmodule

bind threshold_box_dilation_mask_top tbdm_checker u_tbdm_checker (.*);
